// ----- src/dual_tone_curve_mapper_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the tone curve mapper
// Immediate-consequence and next-cycle property forms, clocked on clk and
// disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef DUAL_TONE_CURVE_MAPPER_UNIT_ASSERT_SVH
`define DUAL_TONE_CURVE_MAPPER_UNIT_ASSERT_SVH

// cons must hold in the same cycle as ante
`define DTCM_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// cons must hold in the cycle after ante
`define DTCM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/dtcm_pkg.sv -----
// ----------------------------------------------------------------------------
// dtcm_pkg
// Shared types and constants of the dual tone curve mapper.
// ----------------------------------------------------------------------------
package dtcm_pkg;

	localparam int unsigned CFG_IDX_W = 3;

	typedef logic [7:0] pix_t;

	localparam pix_t FULL_SCALE = 8'd255;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_KNEE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SLOPE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_END    = 3'd4;

	// register reset values
	localparam pix_t KNEE_RST   = 8'd32;
	localparam pix_t GAIN_RST   = 8'd224;
	localparam pix_t SLOPE_RST  = 8'd32;
	localparam pix_t OFFSET_RST = 8'd64;
	localparam pix_t END_RST    = 8'd200;

	// a, b, c, d, e of the curve definition
	typedef struct packed {
		pix_t knee;
		pix_t gain;
		pix_t slope;
		pix_t offset;
		pix_t high;
	} cfg_t;

	// derived breakpoints
	typedef struct packed {
		pix_t p1;
		pix_t p2;
		pix_t pd;
	} bp_t;

	typedef enum logic [1:0] {
		BP_IDLE,
		BP_LOAD,
		BP_CHECK,
		BP_STEP
	} bp_state_t;

	typedef enum logic [1:0] {
		SEL_P1,
		SEL_P2,
		SEL_PD
	} bp_sel_t;

endpackage

// ----- src/dtcm_bp_unit.sv -----
// ----------------------------------------------------------------------------
// dtcm_bp_unit
// Derives the three breakpoints from the curve registers with one shared
// restoring divider, one quotient bit per cycle. Restarts on any write.
// ----------------------------------------------------------------------------
module dtcm_bp_unit
	import dtcm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic restart,
	input  cfg_t cfg,
	output bp_t  bp,
	output logic ready
);

	bp_state_t          state_q, state_d;
	bp_sel_t            sel_q, sel_d;
	logic [2:0]         cnt_q, cnt_d;
	logic [24:0]        num_q, num_d;
	logic signed [17:0] den_q, den_d;
	logic [16:0]        rem_q, rem_d;
	logic [7:0]         quo_q, quo_d;
	bp_t                bp_q, bp_d;

	pix_t               na;
	logic [15:0]        prod_ab, prod_ac, prod_nd, b255, d255;
	logic [16:0]        inner;
	logic signed [8:0]  bmc, dme;
	logic signed [17:0] bmc18, na17, dme17, prod_nde;
	logic signed [17:0] ld_den;
	logic [24:0]        ld_num;
	pix_t               num_lo;
	logic [17:0]        trial;
	logic               qbit;
	logic               res_we;
	pix_t               res;
	logic               advance;

	// operand formation
	always_comb begin
		na       = FULL_SCALE - cfg.knee;
		prod_ab  = {8'd0, cfg.knee} * {8'd0, cfg.gain};
		prod_ac  = {8'd0, cfg.knee} * {8'd0, cfg.slope};
		prod_nd  = {8'd0, na} * {8'd0, cfg.offset};
		b255     = {cfg.gain, 8'd0} - {8'd0, cfg.gain};
		d255     = {cfg.offset, 8'd0} - {8'd0, cfg.offset};
		inner    = {1'b0, prod_nd} + {1'b0, prod_ab};
		bmc      = $signed({1'b0, cfg.gain}) - $signed({1'b0, cfg.slope});
		dme      = $signed({1'b0, cfg.offset}) - $signed({1'b0, cfg.high});
		bmc18    = {{9{bmc[8]}}, bmc};
		na17     = $signed({10'd0, na});
		dme17    = {{9{dme[8]}}, dme};
		prod_nde = na17 * dme17;
		case (sel_q)
			SEL_P1: begin
				ld_num = {1'b0, prod_ab, 8'd0} - {9'd0, prod_ab};
				ld_den = (bmc18 <<< 8) - bmc18 - $signed({2'b0, prod_ac});
			end
			SEL_P2: begin
				// numerator of p2 runs to 25 bits
				ld_num = {inner, 8'd0} - {8'd0, inner};
				ld_den = prod_nde + $signed({2'b0, b255});
			end
			SEL_PD: begin
				ld_num = {9'd0, d255};
				ld_den = 18'sd255 + $signed({10'd0, cfg.offset})
					- $signed({10'd0, cfg.high});
			end
			default: begin
				ld_num = '0;
				ld_den = '0;
			end
		endcase
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		sel_d   = sel_q;
		cnt_d   = cnt_q;
		num_d   = num_q;
		den_d   = den_q;
		rem_d   = rem_q;
		quo_d   = quo_q;
		bp_d    = bp_q;
		res     = '0;
		res_we  = 1'b0;
		num_lo  = num_q[7:0];
		trial   = {rem_q, num_lo[cnt_q]};
		qbit    = (trial >= {1'b0, den_q[16:0]});

		case (state_q)
			BP_IDLE: begin
			end
			BP_LOAD: begin
				num_d   = ld_num;
				den_d   = ld_den;
				state_d = BP_CHECK;
			end
			BP_CHECK: begin
				if (den_q == '0) begin
					res    = FULL_SCALE;
					res_we = 1'b1;
				end else if (den_q[17]) begin
					res    = '0;
					res_we = 1'b1;
				end else if (num_q[24:8] >= den_q[16:0]) begin
					res    = FULL_SCALE;
					res_we = 1'b1;
				end else begin
					rem_d   = num_q[24:8];
					cnt_d   = 3'd7;
					state_d = BP_STEP;
				end
			end
			BP_STEP: begin
				rem_d = qbit ? 17'(trial - {1'b0, den_q[16:0]}) : trial[16:0];
				quo_d = {quo_q[6:0], qbit};
				if (cnt_q == 3'd0) begin
					res    = {quo_q[6:0], qbit};
					res_we = 1'b1;
				end else begin
					cnt_d = cnt_q - 3'd1;
				end
			end
			default: state_d = BP_IDLE;
		endcase

		advance = res_we;
		if (res_we) begin
			case (sel_q)
				SEL_P1:  bp_d.p1 = res;
				SEL_P2:  bp_d.p2 = res;
				SEL_PD:  bp_d.pd = res;
				default: bp_d    = bp_q;
			endcase
		end
		if (advance) begin
			case (sel_q)
				SEL_P1: begin
					sel_d   = SEL_P2;
					state_d = BP_LOAD;
				end
				SEL_P2: begin
					sel_d   = SEL_PD;
					state_d = BP_LOAD;
				end
				default: state_d = BP_IDLE;
			endcase
		end

		if (restart) begin
			state_d = BP_LOAD;
			sel_d   = SEL_P1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BP_LOAD;
			sel_q   <= SEL_P1;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			sel_q   <= sel_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		num_q <= num_d;
		den_q <= den_d;
		rem_q <= rem_d;
		quo_q <= quo_d;
		bp_q  <= bp_d;
	end

	assign bp    = bp_q;
	assign ready = (state_q == BP_IDLE);

endmodule

// ----- src/dtcm_seg_pipe.sv -----
// ----------------------------------------------------------------------------
// dtcm_seg_pipe
// Six-stage sample pipeline: segment compare, products, division by 255
// and a pipelined middle-segment divider, two quotient bits per stage.
// ----------------------------------------------------------------------------
module dtcm_seg_pipe
	import dtcm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic take,
	input  pix_t luma,
	input  cfg_t cfg,
	input  bp_t  bp,
	output logic rdy,
	output logic out_valid,
	input  logic out_stall,
	output pix_t bright,
	output pix_t dark
);

	typedef struct packed {
		logic lt_p1;
		logic lt_p2;
		pix_t low_q;
		pix_t up_q;
		pix_t dark;
		logic kill;
		logic sat;
		pix_t rem;
		pix_t quo;
		pix_t lo;
		pix_t den;
	} mid_t;

	// x / 255 for x below 2^16: estimate, then one correction
	function automatic pix_t div255(input logic [15:0] x);
		logic [16:0] sum;
		logic [8:0]  q0;
		logic [16:0] r;
		sum = {1'b0, x} + {9'd0, x[15:8]};
		q0  = sum[16:8];
		r   = {1'b0, x} - ({q0, 8'd0} - {8'd0, q0});
		if (r >= 17'd255) q0 = q0 + 9'd1;
		return q0[7:0];
	endfunction

	// one restoring step: {next remainder, quotient bit}
	function automatic logic [8:0] mid_step(input pix_t rem, input logic nb,
		input pix_t den);
		logic [8:0] t;
		t = {rem, nb};
		if (t >= {1'b0, den}) return {8'(t - {1'b0, den}), 1'b1};
		return {t[7:0], 1'b0};
	endfunction

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic r1, r2, r3, r4, r5, r6;

	// stage 1
	pix_t luma_s1, diff_s1, den_s1;
	logic lt_p1_s1, lt_p2_s1, lt_pd_s1, kill_s1;
	// stage 2
	pix_t luma_s2, den_s2;
	logic lt_p1_s2, lt_p2_s2, lt_pd_s2, kill_s2;
	logic [15:0] low_num_s2, mid_num_s2, up_num_s2;
	logic [16:0] up_sum;
	// stages 3..6
	mid_t st3_d, st4_d, st5_d, st3_s3, st4_s4, st5_s5;
	logic [8:0] a3, b3, a4, b4, a5, b5, a6, b6;
	pix_t quo_full, mid_val;
	pix_t bright_s6, dark_s6;

	assign r6  = !v_s6 || !out_stall;
	assign r5  = !v_s5 || r6;
	assign r4  = !v_s4 || r5;
	assign r3  = !v_s3 || r4;
	assign r2  = !v_s2 || r3;
	assign r1  = !v_s1 || r2;
	assign rdy = r1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (r1) v_s1 <= take;
			if (r2) v_s2 <= v_s1;
			if (r3) v_s3 <= v_s2;
			if (r4) v_s4 <= v_s3;
			if (r5) v_s5 <= v_s4;
			if (r6) v_s6 <= v_s5;
		end
	end

	// stage 1: segment decisions
	always_ff @(posedge clk) begin
		if (r1) begin
			luma_s1  <= luma;
			lt_p1_s1 <= (luma < bp.p1);
			lt_p2_s1 <= (luma < bp.p2);
			lt_pd_s1 <= (luma < bp.pd);
			kill_s1  <= (luma < cfg.knee) || (cfg.knee == FULL_SCALE);
			diff_s1  <= luma - cfg.knee;
			den_s1   <= FULL_SCALE - cfg.knee;
		end
	end

	// stage 2: products
	assign up_sum = {1'b0, {8'd0, cfg.high} * {8'd0, luma_s1}}
		+ {1'b0, {8'd0, cfg.offset} * {8'd0, FULL_SCALE - luma_s1}};

	always_ff @(posedge clk) begin
		if (r2) begin
			luma_s2    <= luma_s1;
			lt_p1_s2   <= lt_p1_s1;
			lt_p2_s2   <= lt_p2_s1;
			lt_pd_s2   <= lt_pd_s1;
			kill_s2    <= kill_s1;
			den_s2     <= den_s1;
			low_num_s2 <= {8'd0, cfg.slope} * {8'd0, luma_s1};
			mid_num_s2 <= {8'd0, cfg.gain} * {8'd0, diff_s1};
			up_num_s2  <= up_sum[15:0];
		end
	end

	// stage 3: /255 paths, divider setup and quotient bits 7..6
	always_comb begin
		st3_d.lt_p1 = lt_p1_s2;
		st3_d.lt_p2 = lt_p2_s2;
		st3_d.low_q = div255(low_num_s2);
		st3_d.up_q  = div255(up_num_s2);
		st3_d.dark  = lt_pd_s2 ? luma_s2 : st3_d.up_q;
		st3_d.kill  = kill_s2;
		st3_d.sat   = (mid_num_s2[15:8] >= den_s2);
		st3_d.lo    = mid_num_s2[7:0];
		st3_d.den   = den_s2;
		a3          = mid_step(mid_num_s2[15:8], mid_num_s2[7], den_s2);
		b3          = mid_step(a3[8:1], mid_num_s2[6], den_s2);
		st3_d.rem   = b3[8:1];
		st3_d.quo   = {6'd0, a3[0], b3[0]};
	end

	// stage 4: bits 5..4
	always_comb begin
		st4_d     = st3_s3;
		a4        = mid_step(st3_s3.rem, st3_s3.lo[5], st3_s3.den);
		b4        = mid_step(a4[8:1], st3_s3.lo[4], st3_s3.den);
		st4_d.rem = b4[8:1];
		st4_d.quo = {st3_s3.quo[5:0], a4[0], b4[0]};
	end

	// stage 5: bits 3..2
	always_comb begin
		st5_d     = st4_s4;
		a5        = mid_step(st4_s4.rem, st4_s4.lo[3], st4_s4.den);
		b5        = mid_step(a5[8:1], st4_s4.lo[2], st4_s4.den);
		st5_d.rem = b5[8:1];
		st5_d.quo = {st4_s4.quo[5:0], a5[0], b5[0]};
	end

	// stage 6: bits 1..0 and curve selection
	always_comb begin
		a6       = mid_step(st5_s5.rem, st5_s5.lo[1], st5_s5.den);
		b6       = mid_step(a6[8:1], st5_s5.lo[0], st5_s5.den);
		quo_full = {st5_s5.quo[5:0], a6[0], b6[0]};
		if (st5_s5.kill)     mid_val = '0;
		else if (st5_s5.sat) mid_val = FULL_SCALE;
		else                 mid_val = quo_full;
	end

	always_ff @(posedge clk) begin
		if (r3) st3_s3 <= st3_d;
		if (r4) st4_s4 <= st4_d;
		if (r5) st5_s5 <= st5_d;
		if (r6) begin
			if (st5_s5.lt_p1)      bright_s6 <= st5_s5.low_q;
			else if (st5_s5.lt_p2) bright_s6 <= mid_val;
			else                   bright_s6 <= st5_s5.up_q;
			dark_s6 <= st5_s5.dark;
		end
	end

	assign out_valid = v_s6;
	assign bright    = bright_s6;
	assign dark      = dark_s6;

endmodule

// ----- src/dual_tone_curve_mapper_unit.sv -----
// ----------------------------------------------------------------------------
// dual_tone_curve_mapper_unit
// Maps 8-bit luma through a bright and a dark piecewise-linear tone curve.
//
// Input channel (in_valid / in_stall / luma_in): one sample per transfer.
// Output channel (out_valid / out_stall / bright_value, dark_value): one
// result per sample, in order. Configuration: cfg_we with cfg_index 0..4
// selects knee, gain, slope, offset, end; other indexes are ignored.
// Throughput: one transfer per clock on both sides while neither side is
// stalled. Each sample passes through the six-stage sample pipeline before
// its result is offered on the output.
// A receiver stall freezes the pipeline in place; in_stall rises once the
// pipeline is full, so nothing is dropped or repeated.
// Breakpoints come from a shared bit-serial divider: after reset and after
// every register write the input is stalled while the three breakpoints
// are rebuilt from the registers, one after another.
// Reset clears the pipeline and loads the register defaults.
// ----------------------------------------------------------------------------
`include "dual_tone_curve_mapper_unit_assert.svh"

module dual_tone_curve_mapper_unit
	import dtcm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data,
	// sample input
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           luma_in,
	// result output
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [7:0]           bright_value,
	output logic [7:0]           dark_value
);

	cfg_t cfg_q;
	bp_t  bp;
	logic bp_ready;
	logic pipe_rdy;
	logic take;

	// curve registers; the user must let writes arrive only while the block is drained, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.knee   <= KNEE_RST;
			cfg_q.gain   <= GAIN_RST;
			cfg_q.slope  <= SLOPE_RST;
			cfg_q.offset <= OFFSET_RST;
			cfg_q.high   <= END_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KNEE:   cfg_q.knee   <= cfg_data;
				REG_GAIN:   cfg_q.gain   <= cfg_data;
				REG_SLOPE:  cfg_q.slope  <= cfg_data;
				REG_OFFSET: cfg_q.offset <= cfg_data;
				REG_END:    cfg_q.high   <= cfg_data;
				default:    cfg_q        <= cfg_q;
			endcase
		end
	end

	// breakpoint rebuild; any write restarts it, even one to an unused index
	dtcm_bp_unit u_bp (
		.clk     (clk),
		.arst_n  (arst_n),
		.restart (cfg_we),
		.cfg     (cfg_q),
		.bp      (bp),
		.ready   (bp_ready)
	);

	// input is held off while breakpoints are stale or the pipe is backed up
	assign in_stall = !(bp_ready && pipe_rdy);
	assign take     = in_valid && !in_stall;

	dtcm_seg_pipe u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.luma      (luma_in),
		.cfg       (cfg_q),
		.bp        (bp),
		.rdy       (pipe_rdy),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.bright    (bright_value),
		.dark      (dark_value)
	);

	// a register write must stall the input on the following cycle
	`DTCM_ASSERT_NEXT(a_cfg_blocks_input, cfg_we, in_stall, "input open after a register write")
	// breakpoints stay settled until the next write
	`DTCM_ASSERT_NEXT(a_bp_stays_ready, bp_ready && !cfg_we, bp_ready, "breakpoints restarted")
	// no sample transfer against stale breakpoints
	`DTCM_ASSERT_SAME(a_take_needs_bp, in_valid && !in_stall, bp_ready, "sample taken too early")

endmodule

// ----- tb/dual_tone_curve_mapper_unit_test.sv -----
// ----------------------------------------------------------------------------
// dual_tone_curve_mapper_unit_test
// Self-checking bench for the dual tone curve mapper. A queue-fed driver
// offers luma samples and a monitor checks every result transfer against a
// local copy of both curves. The curves are reprogrammed between phases
// only, while nothing is in flight. Phases cover directed corner curves,
// random curves with samples aimed at the breakpoints, several idle and
// stall patterns, and one long receiver hold-off that backs up the pipeline.
// ----------------------------------------------------------------------------
module dual_tone_curve_mapper_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import dtcm_pkg::*;

	localparam longint      FULL         = 255;
	localparam int unsigned NUM_REGS     = 5;
	localparam int unsigned RESET_CYCLES = 10;
	localparam int unsigned LIMIT_CYCLES = 200000;
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned DRAIN_CYCLES = 20;
	localparam int unsigned RAND_PHASES  = 12;
	localparam int unsigned RAND_ITEMS   = 75;
	localparam int unsigned IDLE_HEAVY   = 57;
	localparam int unsigned IDLE_LIGHT   = 12;

	// one expected result: both curve outputs of one sample
	typedef struct packed {
		pix_t bright;
		pix_t dark;
	} tone_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [7:0]           cfg_data  = '0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	logic [7:0]           luma_in   = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [7:0]           bright_value;
	logic [7:0]           dark_value;

	// shadow of the curve registers, starts at the reset values
	cfg_t        cur_curve = '{KNEE_RST, GAIN_RST, SLOPE_RST, OFFSET_RST, END_RST};
	pix_t        pending_luma[$];
	tone_t       expected_tones[$];
	int unsigned send_gap_pct  = 0;
	int unsigned stall_pct     = 0;
	bit          long_hold_req = 1'b0;
	int unsigned hold_left     = 0;
	int unsigned errors        = 0;
	int unsigned cycle_count   = 0;

	dual_tone_curve_mapper_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.luma_in      (luma_in),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.bright_value (bright_value),
		.dark_value   (dark_value)
	);

	// ------------------------------------------------------------------
	// Curve arithmetic
	// ------------------------------------------------------------------

	// truncating divide clipped to 0..255; zero divisor gives on_zero
	function automatic longint clip_div(longint num, longint den, longint on_zero);
		longint q;
		if (den == 0)
			return on_zero;
		q = num / den;
		if (q < 0)
			return 0;
		if (q > FULL)
			return FULL;
		return q;
	endfunction

	// the three breakpoints a curve setting implies
	function automatic bp_t curve_breaks(cfg_t cf);
		longint a, b, c, d, e;
		bp_t    bp;
		a = cf.knee;
		b = cf.gain;
		c = cf.slope;
		d = cf.offset;
		e = cf.high;
		bp.p1 = pix_t'(clip_div(FULL * b * a, FULL * (b - c) - a * c, FULL));
		bp.p2 = pix_t'(clip_div(FULL * ((FULL - a) * d + a * b),
			(FULL - a) * (d - e) + FULL * b, FULL));
		bp.pd = pix_t'(clip_div(FULL * d, FULL + d - e, FULL));
		return bp;
	endfunction

	// both curve outputs for one sample
	function automatic tone_t tone_map(cfg_t cf, pix_t luma);
		longint a, b, c, d, e, i, upper;
		bp_t    bp;
		tone_t  r;
		a = cf.knee;
		b = cf.gain;
		c = cf.slope;
		d = cf.offset;
		e = cf.high;
		i = luma;
		bp = curve_breaks(cf);
		// shared upper segment
		upper = clip_div((e - d) * i + FULL * d, FULL, 0);
		if (i < longint'(bp.p1))
			r.bright = pix_t'(clip_div(c * i, FULL, 0));
		else if (i < longint'(bp.p2))
			r.bright = pix_t'(clip_div(b * (i - a), FULL - a, 0));
		else
			r.bright = pix_t'(upper);
		// dark curve passes the sample through below its breakpoint
		r.dark = (i < longint'(bp.pd)) ? luma : pix_t'(upper);
		return r;
	endfunction

	// register value biased toward the extremes
	function automatic pix_t pick_reg();
		case ($urandom_range(3))
			0: return 8'd0;
			1: return 8'd255;
			default: return pix_t'($urandom_range(255));
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Clock, reset release and run limit
	// ------------------------------------------------------------------
	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == RESET_CYCLES - 1)
			arst_n <= 1'b1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Driver: feeds pending samples, one transfer per accepted edge.
	// The expectation is computed at the transfer, with the curve that
	// stays fixed for the whole phase.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				expected_tones.push_back(tone_map(cur_curve, luma_in));
			// payload may only move when the slot is empty or just transferred
			if (!in_valid || !in_stall) begin
				if (pending_luma.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
					in_valid <= 1'b1;
					luma_in  <= pending_luma.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: checks each result transfer against the oldest expectation,
	// then decides the stall for the next edge. A hold-off request from the
	// sequence is counted down here.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		tone_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_tones.size() == 0) begin
					errors++;
					$display("%0t unexpected result: expected none, actual bright %0d dark %0d",
						$time, bright_value, dark_value);
				end else begin
					want = expected_tones.pop_front();
					if (bright_value !== want.bright) begin
						errors++;
						$display("%0t bright_value: expected %0d, actual %0d",
							$time, want.bright, bright_value);
					end
					if (dark_value !== want.dark) begin
						errors++;
						$display("%0t dark_value: expected %0d, actual %0d",
							$time, want.dark, dark_value);
					end
				end
			end
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left     = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	// one register write; cfg_we is dropped by the caller
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input pix_t val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_KNEE:   cur_curve.knee   = val;
			REG_GAIN:   cur_curve.gain   = val;
			REG_SLOPE:  cur_curve.slope  = val;
			REG_OFFSET: cur_curve.offset = val;
			REG_END:    cur_curve.high   = val;
			default: ;  // outside the register list, no effect
		endcase
	endtask

	// nothing queued, nothing offered, nothing outstanding
	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_luma.size() != 0 || in_valid || expected_tones.size() != 0);
	endtask

	// drain, reprogram all registers, set the idle pattern for the phase
	task automatic start_phase(input cfg_t cf, input bit stray,
		input int unsigned gap, input int unsigned stall);
		wait_idle();
		if (stray)
			write_reg(CFG_IDX_W'($urandom_range(2 ** CFG_IDX_W - 1, NUM_REGS)),
				pix_t'($urandom_range(255)));
		write_reg(REG_KNEE,   cf.knee);
		write_reg(REG_GAIN,   cf.gain);
		write_reg(REG_SLOPE,  cf.slope);
		write_reg(REG_OFFSET, cf.offset);
		write_reg(REG_END,    cf.high);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		send_gap_pct = gap;
		stall_pct    = stall;
	endtask

	task automatic push_four(input logic [31:0] four);
		for (int k = 3; k >= 0; k--)
			pending_luma.push_back(four[8*k +: 8]);
	endtask

	initial begin
		cfg_t        cf;
		bp_t         bp;
		int          v;
		int unsigned gap, stall;

		wait (arst_n);
		@(negedge clk);

		// reset curve, ends of the range and around the knee
		push_four({8'd0, 8'd1, 8'd32, 8'd33});
		push_four({8'd127, 8'd128, 8'd254, 8'd255});

		// knee at full scale: middle segment divides by zero; dark breakpoint
		// denominator is zero as well
		start_phase('{8'd255, 8'd100, 8'd100, 8'd0, 8'd255}, 1'b0, 0, 0);
		push_four({8'd0, 8'd100, 8'd254, 8'd255});

		// negative first-breakpoint divisor, middle segment below the knee
		start_phase('{8'd200, 8'd50, 8'd100, 8'd0, 8'd0}, 1'b0, 0, 0);
		push_four({8'd0, 8'd150, 8'd199, 8'd200});

		// all registers at zero
		start_phase('{8'd0, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b0, 0, 0);
		push_four({8'd0, 8'd1, 8'd128, 8'd255});

		// all registers at full scale
		start_phase('{8'd255, 8'd255, 8'd255, 8'd255, 8'd255}, 1'b0, 0, 0);
		push_four({8'd0, 8'd128, 8'd254, 8'd255});

		// first breakpoint saturates above full scale, falling upper segment
		start_phase('{8'd2, 8'd100, 8'd99, 8'd255, 8'd0}, 1'b0, 0, 0);
		push_four({8'd0, 8'd3, 8'd200, 8'd255});

		// random curves, cycling through the idle patterns
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			cf = '{pick_reg(), pick_reg(), pick_reg(), pick_reg(), pick_reg()};
			case (ph % 4)
				0: begin gap = 0;          stall = 0;          end
				1: begin gap = IDLE_HEAVY; stall = 0;          end
				2: begin gap = 0;          stall = IDLE_HEAVY; end
				default: begin gap = IDLE_LIGHT; stall = IDLE_LIGHT; end
			endcase
			start_phase(cf, bit'($urandom_range(1)), gap, stall);
			// long hold-off with a busy sender: pipeline fills, input stalls
			if (ph == 4)
				long_hold_req = 1'b1;
			bp = curve_breaks(cf);
			for (int n = 0; n < RAND_ITEMS; n++) begin
				if ($urandom_range(9) < 3) begin
					// land close to one of the breakpoints
					case ($urandom_range(2))
						0: v = bp.p1;
						1: v = bp.p2;
						default: v = bp.pd;
					endcase
					v = v + int'($urandom_range(4)) - 2;
					if (v < 0)
						v = 0;
					if (v > 255)
						v = 255;
				end else begin
					v = $urandom_range(255);
				end
				pending_luma.push_back(pix_t'(v));
			end
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
